// File: hdl/oil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oil_pkg: shared types and constants for the ordered index list
// Action codes, field widths, controller states and the per-cell command.
// ----------------------------------------------------------------------------
package oil_pkg;

  localparam int VALUE_W  = 16;
  localparam int POS_W    = 10;
  localparam int RESULT_W = 17;
  localparam int COUNT_W  = 11;
  localparam int ACTION_W = 3;

  // Cells are gathered in groups of this size before the final reduction.
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_W    = 3;

  localparam logic signed [RESULT_W-1:0] RESULT_NONE = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD        = 3'd0,
    ACT_REMOVE_ALL = 3'd1,
    ACT_REMOVE_AT  = 3'd2,
    ACT_READ_AT    = 3'd3,
    ACT_FIND       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_RESOLVE,
    ST_PEND
  } state_t;

  typedef struct packed {
    logic push;  // every cell takes its left neighbor's entry
    logic pull;  // cells at or after the kill index take their right neighbor's entry
  } cell_cmd_t;

endpackage

// File: hdl/ordered_index_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_index_list: bounded list of index values, newest at position 0
// A row of shifting cells holds the entries; a controller sequences each
// transaction through a gather cycle and a resolve cycle.
// ----------------------------------------------------------------------------
// An accepted transaction is registered, then the gather cycle registers the group stage
// of the match tree, and the resolve cycle registers the result, or holds it in the pending
// registers while out_stall is set. Remove-all repeats gather and resolve until no match
// is left, as the cell row closes one gap per pass. A new transaction may be accepted in
// the resolve cycle that ends the last one if the output is free. Reset clears the entry
// count and control state; cells are not cleared and are never read at or above the count.
module ordered_index_list
  import oil_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        in_action,
  input  logic [VALUE_W-1:0]         in_value,
  input  logic [POS_W-1:0]           in_position,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] out_result_value,
  output logic                       out_found,
  output logic [COUNT_W-1:0]         out_entry_count,
  output logic                       out_overflow
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [ACTION_W-1:0] action_r;
  logic [VALUE_W-1:0]  value_r;
  logic [POS_W-1:0]    pos_r;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [RESULT_W-1:0] out_result_value_r;
  logic                       out_found_r;
  logic [COUNT_W-1:0]         out_entry_count_r;
  logic                       out_overflow_r;

  logic                       pend_load;
  logic signed [RESULT_W-1:0] pend_result_value_r;
  logic                       pend_found_r;
  logic [COUNT_W-1:0]         pend_entry_count_r;
  logic                       pend_overflow_r;

  logic                       res_load;
  logic signed [RESULT_W-1:0] res_value;
  logic                       res_found;
  logic                       res_overflow;
  logic                       more;
  logic                       finishing;
  logic                       out_free;
  logic                       in_accept;
  logic                       pos_ok;

  cell_cmd_t        cmd;
  logic [IDX_W-1:0] kill_idx;

  logic [VALUE_W-1:0] cell_data  [CAPACITY];
  logic               cell_match [CAPACITY];
  logic               cell_sel   [CAPACITY];

  logic               any_match;
  logic [IDX_W-1:0]   first_idx;
  logic [VALUE_W-1:0] sel_data;

  // ---------------------------------------------------------------- cell row
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_d;
      logic [VALUE_W-1:0] right_d;

      if (i == 0) begin : g_head
        assign left_d = value_r;
      end else begin : g_body
        assign left_d = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_d = '0;
      end else begin : g_next
        assign right_d = cell_data[i+1];
      end

      oil_cell #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .INDEX (i)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .kill_idx   (kill_idx),
        .key        (value_r),
        .sel_pos    (pos_r[IDX_W-1:0]),
        .count      (count_r),
        .left_data  (left_d),
        .right_data (right_d),
        .data_o     (cell_data[i]),
        .match_o    (cell_match[i]),
        .sel_o      (cell_sel[i])
      );
    end
  endgenerate

  oil_gather #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_gather (
    .clk        (clk),
    .cell_data  (cell_data),
    .cell_match (cell_match),
    .cell_sel   (cell_sel),
    .any_match  (any_match),
    .first_idx  (first_idx),
    .sel_data   (sel_data)
  );

  // ------------------------------------------------------------- resolution
  assign pos_ok   = {1'b0, pos_r} < COUNT_W'(count_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    kill_idx     = '0;
    count_nxt    = count_r;
    res_value    = RESULT_NONE;
    res_found    = 1'b0;
    res_overflow = 1'b0;
    more         = 1'b0;
    if (state_r == ST_RESOLVE) begin
      unique case (action_r)
        ACT_ADD: begin
          if (count_r == FULL_COUNT) begin
            res_overflow = 1'b1;
          end else begin
            cmd.push  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ACT_REMOVE_ALL: begin
          // Each pass deletes the lowest match; the loop ends when none is left.
          if (any_match) begin
            cmd.pull  = 1'b1;
            kill_idx  = first_idx;
            count_nxt = count_r - CNT_W'(1);
            more      = 1'b1;
          end
        end
        ACT_REMOVE_AT: begin
          if (pos_ok) begin
            res_value = $signed({1'b0, sel_data});
            res_found = 1'b1;
            cmd.pull  = 1'b1;
            kill_idx  = pos_r[IDX_W-1:0];
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ACT_READ_AT: begin
          if (pos_ok) begin
            res_value = $signed({1'b0, sel_data});
            res_found = 1'b1;
          end
        end
        ACT_FIND: begin
          if (any_match) begin
            res_value = $signed({1'b0, value_r});
            res_found = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign finishing = (state_r == ST_RESOLVE) && !more;
  assign res_load  = finishing && out_free;
  assign pend_load = finishing && !out_free;

  assign in_stall  = !((state_r == ST_IDLE) || res_load);
  assign in_accept = in_valid && !in_stall;

  // ------------------------------------------------------------ controller
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_GATHER;
        end
      end
      ST_GATHER: begin
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        priority if (more) begin
          state_nxt = ST_GATHER;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_accept ? ST_GATHER : ST_IDLE;
        end else begin
          state_nxt = ST_PEND;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r <= in_action;
      value_r  <= in_value;
      pos_r    <= in_position;
    end
    if (pend_load) begin
      pend_result_value_r <= res_value;
      pend_found_r        <= res_found;
      pend_entry_count_r  <= COUNT_W'(count_nxt);
      pend_overflow_r     <= res_overflow;
    end
    if (res_load) begin
      out_result_value_r <= res_value;
      out_found_r        <= res_found;
      out_entry_count_r  <= COUNT_W'(count_nxt);
      out_overflow_r     <= res_overflow;
    end else if ((state_r == ST_PEND) && out_free) begin
      out_result_value_r <= pend_result_value_r;
      out_found_r        <= pend_found_r;
      out_entry_count_r  <= pend_entry_count_r;
      out_overflow_r     <= pend_overflow_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_found        = out_found_r;
  assign out_entry_count  = out_entry_count_r;
  assign out_overflow     = out_overflow_r;

  // ------------------------------------------------------------ assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count exceeds capacity");

  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RESOLVE) |=> $stable(count_r))
    else $error("entry count changed outside the resolve cycle");

  a_accept_gathers: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_GATHER))
    else $error("accepted transaction did not enter the gather cycle");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_overflow_r) |-> (out_entry_count_r == COUNT_W'(CAPACITY)))
    else $error("overflow reported on a list that is not full");

  a_absent_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_result_value_r == RESULT_NONE))
    else $error("result value set without a found entry");

endmodule

// File: hdl/oil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oil_cell: one list slot
// Holds one entry, compares it against the key and position, and shifts
// toward either neighbor on command.
// ----------------------------------------------------------------------------
module oil_cell
  import oil_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [IDX_W-1:0]   kill_idx,
  input  logic [VALUE_W-1:0] key,
  input  logic [IDX_W-1:0]   sel_pos,
  input  logic [CNT_W-1:0]   count,
  input  logic [VALUE_W-1:0] left_data,
  input  logic [VALUE_W-1:0] right_data,
  output logic [VALUE_W-1:0] data_o,
  output logic               match_o,
  output logic               sel_o
);

  localparam logic [CNT_W-1:0] INDEX_CNT = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] INDEX_IDX = IDX_W'(INDEX);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;
  logic               live;

  assign live    = INDEX_CNT < count;
  assign match_o = live && (data_r == key);
  assign sel_o   = (INDEX_IDX == sel_pos);
  assign data_o  = data_r;

  always_comb begin
    data_nxt = data_r;
    priority if (cmd.push) begin
      data_nxt = left_data;
    end else if (cmd.pull && (INDEX_IDX >= kill_idx)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: hdl/oil_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oil_gather: registered reduction over the cell row
// Finds the lowest matching cell and the entry at the selected position
// in two levels, with a register between the group and final stages.
// ----------------------------------------------------------------------------
module oil_gather
  import oil_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6
) (
  input  logic               clk,
  input  logic [VALUE_W-1:0] cell_data [CAPACITY],
  input  logic               cell_match [CAPACITY],
  input  logic               cell_sel [CAPACITY],
  output logic               any_match,
  output logic [IDX_W-1:0]   first_idx,
  output logic [VALUE_W-1:0] sel_data
);

  localparam int NG  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD = NG * GROUP_SIZE;

  logic [VALUE_W-1:0] data_pad  [PAD];
  logic               match_pad [PAD];
  logic               sel_pad   [PAD];

  logic               grp_any_r   [NG];
  logic [GROUP_W-1:0] grp_first_r [NG];
  logic [VALUE_W-1:0] grp_data_r  [NG];

  logic               grp_any_nxt   [NG];
  logic [GROUP_W-1:0] grp_first_nxt [NG];
  logic [VALUE_W-1:0] grp_data_nxt  [NG];

  genvar p;
  generate
    for (p = 0; p < PAD; p++) begin : g_pad
      if (p < CAPACITY) begin : g_real
        assign data_pad[p]  = cell_data[p];
        assign match_pad[p] = cell_match[p];
        assign sel_pad[p]   = cell_sel[p];
      end else begin : g_fill
        assign data_pad[p]  = '0;
        assign match_pad[p] = 1'b0;
        assign sel_pad[p]   = 1'b0;
      end
    end
  endgenerate

  // Group stage: the scan runs downward so the lowest match in a group wins.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_nxt[g]   = 1'b0;
      grp_first_nxt[g] = '0;
      grp_data_nxt[g]  = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
        if (match_pad[g*GROUP_SIZE + k]) begin
          grp_any_nxt[g]   = 1'b1;
          grp_first_nxt[g] = GROUP_W'(k);
        end
        if (sel_pad[g*GROUP_SIZE + k]) begin
          grp_data_nxt[g] = grp_data_nxt[g] | data_pad[g*GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_any_r[g]   <= grp_any_nxt[g];
      grp_first_r[g] <= grp_first_nxt[g];
      grp_data_r[g]  <= grp_data_nxt[g];
    end
  end

  always_comb begin
    any_match = 1'b0;
    first_idx = '0;
    sel_data  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        any_match = 1'b1;
        first_idx = IDX_W'(g * GROUP_SIZE + int'(grp_first_r[g]));
      end
      sel_data = sel_data | grp_data_r[g];
    end
  end

endmodule
